### src/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// Widths, register indexes and defaults shared by the box distance unit.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int COORD_W      = 32;   // Q15.16 coordinate
    localparam int DELTA_W      = 34;   // Q17.16 per-axis delta
    localparam int POS_W        = 32;   // positive delta is below 2^32
    localparam int SQ_W         = 2 * POS_W;
    localparam int SUM_W        = 66;   // three squares, Q.32
    localparam int ROOT_W       = SUM_W / 2;
    localparam int SQRT_STEPS   = SUM_W / 2;
    localparam int REM_W        = ROOT_W + 2;
    localparam int DIST_W       = 34;   // Q17.16 result
    localparam int MAX_AXES     = 3;
    localparam int DIMS_DEFAULT = 3;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLUID  = 3'd6;

endpackage

### src/box_signed_distance_unit.sv
// ----------------------------------------------------------------------------
// box_signed_distance_unit
// Signed distance from a Q15.16 point to an axis-aligned box, fully pipelined.
// ----------------------------------------------------------------------------
// Takes point words and returns one Q17.16 signed distance word per point, in
// order. One stage forms the per-axis deltas, one squares them, one sums the
// squares, 33 stages run a restoring square root one result bit per stage,
// one adds the inside term and one applies the sign. The square root chain
// sets the depth. Throughput is one point per cycle while the skid register
// is empty; a two-entry output (result register plus skid register) keeps
// the input open for one more word after the consumer stalls. Box corners
// and the fluid flag are plain registers written through the cfg port; the
// user must write them only while the unit is idle, unenforced by the block.
module box_signed_distance_unit #(
    parameter int DIMENSIONS = bsd_pkg::DIMS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_wen,
    input  logic [bsd_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [bsd_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [bsd_pkg::COORD_W-1:0]  point_x,
    input  logic signed [bsd_pkg::COORD_W-1:0]  point_y,
    input  logic signed [bsd_pkg::COORD_W-1:0]  point_z,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bsd_pkg::DIST_W-1:0]   signed_distance
);
    import bsd_pkg::*;

    // ---------------- configuration registers ----------------
    logic signed [COORD_W-1:0] low_reg  [MAX_AXES];
    logic signed [COORD_W-1:0] high_reg [MAX_AXES];
    logic                      fluid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_AXES; i++)
            begin
                low_reg[i]  <= '0;
                high_reg[i] <= '0;
            end
            fluid_reg <= 1'b1;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_LOW_X:  low_reg[0]  <= cfg_wdata;
                REG_LOW_Y:  low_reg[1]  <= cfg_wdata;
                REG_LOW_Z:  low_reg[2]  <= cfg_wdata;
                REG_HIGH_X: high_reg[0] <= cfg_wdata;
                REG_HIGH_Y: high_reg[1] <= cfg_wdata;
                REG_HIGH_Z: high_reg[2] <= cfg_wdata;
                REG_FLUID:  fluid_reg   <= cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic                     skid_valid_reg;
    logic signed [DIST_W-1:0] skid_data_reg;
    logic                     p_valid_reg;
    logic signed [DIST_W-1:0] p_data_reg;
    logic                     en;

    // The whole pipe advances unless the skid register holds a word.
    assign en        = !skid_valid_reg;
    assign in_ready  = en;
    assign out_valid = skid_valid_reg | p_valid_reg;
    assign signed_distance = skid_valid_reg ? skid_data_reg : p_data_reg;

    // ---------------- stage 1: per-axis deltas ----------------
    logic signed [COORD_W-1:0] pt [MAX_AXES];
    logic signed [DELTA_W-1:0] delta_next [DIMENSIONS];
    logic signed [DELTA_W-1:0] delta_reg  [DIMENSIONS];
    logic                      v1_reg;

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    always_comb
    begin
        logic signed [DELTA_W-1:0] a;
        logic signed [DELTA_W-1:0] b;
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            a = DELTA_W'(low_reg[i]) - DELTA_W'(pt[i]);
            b = DELTA_W'(pt[i]) - DELTA_W'(high_reg[i]);
            delta_next[i] = (a > b) ? a : b;
        end
    end

    // ---------------- stage 2: squares and inside term ----------------
    logic [SQ_W-1:0]           sq_next  [DIMENSIONS];
    logic [SQ_W-1:0]           sq_reg   [DIMENSIONS];
    logic signed [DELTA_W-1:0] neg_next;
    logic signed [DELTA_W-1:0] neg2_reg;
    logic                      v2_reg;

    always_comb
    begin
        logic signed [DELTA_W-1:0] maxd;
        logic [POS_W-1:0]          pos;
        maxd = delta_reg[0];
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            if (delta_reg[i] > maxd)
                maxd = delta_reg[i];
            pos = (delta_reg[i] > 0) ? delta_reg[i][POS_W-1:0] : '0;
            sq_next[i] = SQ_W'(pos) * SQ_W'(pos);
        end
        neg_next = (maxd < 0) ? maxd : '0;
    end

    // ---------------- stage 3: sum of squares ----------------
    logic [SUM_W-1:0] sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < DIMENSIONS; i++)
            sum_next = sum_next + SUM_W'(sq_reg[i]);
    end

    // ---------------- square root chain ----------------
    // Index 0 is loaded from the sum; each step retires one root bit.
    logic [SUM_W-1:0]          rad_reg  [SQRT_STEPS+1];
    logic [REM_W-1:0]          rem_reg  [SQRT_STEPS+1];
    logic [ROOT_W-1:0]         root_reg [SQRT_STEPS+1];
    logic signed [DELTA_W-1:0] neg_reg  [SQRT_STEPS+1];
    logic                      sv_reg   [SQRT_STEPS+1];

    logic [SUM_W-1:0]  rad_next  [SQRT_STEPS];
    logic [REM_W-1:0]  rem_next  [SQRT_STEPS];
    logic [ROOT_W-1:0] root_next [SQRT_STEPS];

    always_comb
    begin
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            rem_sh = {rem_reg[k], rad_reg[k][SUM_W-1 -: 2]};
            trial  = (REM_W+2)'({root_reg[k], 2'b01});
            rad_next[k] = rad_reg[k] << 2;
            if (rem_sh >= trial)
            begin
                rem_next[k]  = REM_W'(rem_sh - trial);
                root_next[k] = {root_reg[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = REM_W'(rem_sh);
                root_next[k] = {root_reg[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // ---------------- final add and sign ----------------
    logic signed [DIST_W-1:0] fin_next;
    logic signed [DIST_W-1:0] fin_reg;
    logic                     vf_reg;

    assign fin_next = DIST_W'(neg_reg[SQRT_STEPS])
                    + DIST_W'({1'b0, root_reg[SQRT_STEPS]});

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vf_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++)
                sv_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            sv_reg[0] <= v2_reg;
            for (int k = 0; k < SQRT_STEPS; k++)
                sv_reg[k+1] <= sv_reg[k];
            vf_reg      <= sv_reg[SQRT_STEPS];
            p_valid_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIMENSIONS; i++)
            begin
                delta_reg[i] <= delta_next[i];
                sq_reg[i]    <= sq_next[i];
            end
            neg2_reg    <= neg_next;
            rad_reg[0]  <= sum_next;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            neg_reg[0]  <= neg2_reg;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                rad_reg[k+1]  <= rad_next[k];
                rem_reg[k+1]  <= rem_next[k];
                root_reg[k+1] <= root_next[k];
                neg_reg[k+1]  <= neg_reg[k];
            end
            fin_reg    <= fin_next;
            p_data_reg <= fluid_reg ? fin_reg : -fin_reg;
        end
    end

    // ---------------- skid register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (p_valid_reg && !out_ready)
        begin
            // hold the stalled word while the pipe moves on
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && p_valid_reg && !out_ready)
            skid_data_reg <= p_data_reg;
    end

    // ---------------- assertions ----------------
    // The input closes only after a result word was refused.
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(p_valid_reg && !out_ready))
        else $error("in_ready dropped without a refused result");

    // Restoring root: remainder never exceeds twice the root.
    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sv_reg[SQRT_STEPS] |->
            ((REM_W+1)'(rem_reg[SQRT_STEPS]) <= (REM_W+1)'({root_reg[SQRT_STEPS], 1'b0})))
        else $error("square root remainder out of range");

    // A point strictly inside the box has no positive delta, so no length.
    a_inside_root: assert property (@(posedge clk) disable iff (!rst_n)
        (sv_reg[SQRT_STEPS] && neg_reg[SQRT_STEPS] != '0) |->
            (root_reg[SQRT_STEPS] == '0))
        else $error("inside point produced a nonzero length");

    // A word sitting in the skid register holds the pipe frozen.
    a_skid_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && $past(skid_valid_reg)) |-> $stable(p_data_reg))
        else $error("pipeline moved while skid register was full");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box signed distance unit testbench
// Streams Q15.16 points through box_signed_distance_unit under several box
// settings: the reset box, a small ordinary box, the same box with the sign
// flipped, full-range and inverted full-range boxes, then random boxes. A
// scoreboard class predicts each distance as a word is accepted and checks
// the results in order. Sender bursts and receiver stalls vary from phase to
// phase, with some phases running with no idling at all.
// ----------------------------------------------------------------------------
module testbench;

    import bsd_pkg::*;

    localparam int DIMS           = DIMS_DEFAULT;
    localparam int PIPE_LATENCY   = 38;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_POINTS   = 200;

    // index past the register list; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [COORD_W-1:0] ONE       = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the box registers and the queue of distances due
    // ------------------------------------------------------------------------
    class distance_scoreboard;
        longint             box_lo[MAX_AXES];
        longint             box_hi[MAX_AXES];
        bit                 fluid_inside;
        logic [DIST_W-1:0]  distance_q[$];
        int                 fails;
        int                 checked;
        int                 printed;

        function new();
            foreach (box_lo[i])
            begin
                box_lo[i] = 0;
                box_hi[i] = 0;
            end
            fluid_inside = 1'b1;
            fails        = 0;
            checked      = 0;
            printed      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LOW_X:  box_lo[0] = longint'($signed(data));
                REG_LOW_Y:  box_lo[1] = longint'($signed(data));
                REG_LOW_Z:  box_lo[2] = longint'($signed(data));
                REG_HIGH_X: box_hi[0] = longint'($signed(data));
                REG_HIGH_Y: box_hi[1] = longint'($signed(data));
                REG_HIGH_Z: box_hi[2] = longint'($signed(data));
                REG_FLUID:  fluid_inside = data[0];
                default:    ;
            endcase
        endfunction

        function logic [DIST_W-1:0] box_distance(logic signed [COORD_W-1:0] px,
                                                 logic signed [COORD_W-1:0] py,
                                                 logic signed [COORD_W-1:0] pz);
            longint             pt[MAX_AXES];
            longint             to_lo;
            longint             to_hi;
            longint             delta;
            longint             worst;
            longint             sdist;
            logic [DELTA_W-1:0] pos;
            logic [67:0]        sq_sum;
            logic [67:0]        sq;
            logic [33:0]        root;
            logic [33:0]        trial;
            pt[0]  = px;
            pt[1]  = py;
            pt[2]  = pz;
            worst  = 0;
            sq_sum = '0;
            for (int i = 0; i < DIMS; i++)
            begin
                to_lo = box_lo[i] - pt[i];
                to_hi = pt[i] - box_hi[i];
                delta = (to_lo > to_hi) ? to_lo : to_hi;
                if (i == 0 || delta > worst)
                    worst = delta;
                if (delta > 0)
                begin
                    pos    = delta[DELTA_W-1:0];
                    sq_sum = sq_sum + pos * pos;
                end
            end
            // truncated root, one bit at a time from the top
            root = '0;
            for (int b = 33; b >= 0; b--)
            begin
                trial = root | (34'd1 << b);
                sq    = trial * trial;
                if (sq <= sq_sum)
                    root = trial;
            end
            sdist = longint'(root) + ((worst < 0) ? worst : 0);
            if (!fluid_inside)
                sdist = -sdist;
            return sdist[DIST_W-1:0];
        endfunction

        function void note_point(logic signed [COORD_W-1:0] px,
                                 logic signed [COORD_W-1:0] py,
                                 logic signed [COORD_W-1:0] pz);
            distance_q.push_back(box_distance(px, py, pz));
        endfunction

        function int pending();
            return distance_q.size();
        endfunction

        task report(string msg);
            fails++;
            if (printed < 40)
            begin
                printed++;
                $display("[%0t] MISMATCH: %s", $time, msg);
            end
        endtask

        task check_distance(logic [DIST_W-1:0] got);
            logic [DIST_W-1:0] want;
            if (distance_q.size() == 0)
                report($sformatf("distance %h with no point outstanding", got));
            else
            begin
                want = distance_q.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("signed_distance got %h want %h", got, want));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------------
    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]       cfg_wdata = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic signed [COORD_W-1:0]   point_x   = '0;
    logic signed [COORD_W-1:0]   point_y   = '0;
    logic signed [COORD_W-1:0]   point_z   = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [DIST_W-1:0]    signed_distance;

    distance_scoreboard          sb = new();

    logic signed [COORD_W-1:0]   cur_lo[MAX_AXES];
    logic signed [COORD_W-1:0]   cur_hi[MAX_AXES];
    int                          tx_gap_max   = 0;
    int                          tx_burst_max = 1;
    int                          burst_left   = 0;
    int                          rx_stall_pct = 0;
    int                          rx_stall_max = 1;
    int                          stall_left   = 0;
    int                          idle_cycles  = 0;
    int                          points_sent  = 0;
    int                          box_count    = 0;

    box_signed_distance_unit #(
        .DIMENSIONS (DIMS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .point_x         (point_x),
        .point_y         (point_y),
        .point_z         (point_z),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .signed_distance (signed_distance)
    );

    always #5 clk = ~clk;

    // receiver: ready unless inside a stall of random length
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (rst_n && $urandom_range(99) < rx_stall_pct)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(rx_stall_max);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_distance(signed_distance);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no word moved for %0d cycles, %0d distances outstanding",
                     idle_cycles, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // only call while nothing is in flight
    task program_box(logic signed [COORD_W-1:0] lx, logic signed [COORD_W-1:0] ly,
                     logic signed [COORD_W-1:0] lz, logic signed [COORD_W-1:0] hx,
                     logic signed [COORD_W-1:0] hy, logic signed [COORD_W-1:0] hz,
                     logic fluid);
        put_reg(REG_LOW_X, lx);
        put_reg(REG_HIGH_Z, hz);
        put_reg(REG_LOW_Y, ly);
        put_reg(REG_UNUSED, $urandom);
        put_reg(REG_LOW_Z, lz);
        put_reg(REG_HIGH_X, hx);
        put_reg(REG_HIGH_Y, hy);
        put_reg(REG_FLUID, {31'd0, fluid});
        cfg_wen <= 1'b0;
        cur_lo[0] = lx;
        cur_lo[1] = ly;
        cur_lo[2] = lz;
        cur_hi[0] = hx;
        cur_hi[1] = hy;
        cur_hi[2] = hz;
        box_count++;
    endtask

    task send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                    logic signed [COORD_W-1:0] z);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(tx_gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, tx_burst_max);
        end
        burst_left--;
        in_valid <= 1'b1;
        point_x  <= x;
        point_y  <= y;
        point_z  <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_point(x, y, z);
        points_sent++;
    endtask

    // hold the sender until every distance due has come back
    task drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task set_idling(int gap_max, int burst_max, int stall_pct, int stall_max);
        tx_gap_max   = gap_max;
        tx_burst_max = burst_max;
        burst_left   = 0;
        rx_stall_pct = stall_pct;
        rx_stall_max = stall_max;
    endtask

    function automatic void rand_span(output logic signed [COORD_W-1:0] lo,
                                      output logic signed [COORD_W-1:0] hi);
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] t;
        int                        shift;
        bit                        inverted;
        shift    = $urandom_range(2, 14);
        inverted = 1'b0;
        a        = $signed($urandom) >>> shift;
        b        = $signed($urandom) >>> shift;
        case ($urandom_range(9))
            6:       begin a = $urandom; b = $urandom; end
            7:
            begin
                a = $urandom;
                b = $urandom;
                if (a < b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                inverted = 1'b1;
            end
            8:       b = a;
            9:       begin a = COORD_MIN; b = ($urandom_range(1)) ? COORD_MAX : b; end
            default: ;
        endcase
        // well-formed unless the inverted case was picked
        if (a > b && !inverted)
        begin
            lo = b;
            hi = a;
        end
        else
        begin
            lo = a;
            hi = b;
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(longint lo, longint hi);
        longint a;
        longint b;
        longint r;
        longint v;
        longint margin;
        case ($urandom_range(9))
            7, 8:    return $urandom;
            9:
            begin
                case ($urandom_range(5))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return '0;
                    3:       return -1;
                    4:       return lo[COORD_W-1:0];
                    default: return hi[COORD_W-1:0];
                endcase
            end
            default:
            begin
                margin = ($urandom_range(3) == 0) ? $urandom_range(4) : $urandom_range(1 << 20);
                a      = ((lo < hi) ? lo : hi) - margin;
                b      = ((lo < hi) ? hi : lo) + margin;
                r      = longint'({$urandom, $urandom} & 64'h3fff_ffff_ffff_ffff);
                v      = a + r % (b - a + 1);
                if (v > longint'(COORD_MAX))
                    v = COORD_MAX;
                if (v < longint'(COORD_MIN))
                    v = COORD_MIN;
                return v[COORD_W-1:0];
            end
        endcase
    endfunction

    task run_random(int count);
        for (int n = 0; n < count; n++)
            send_point(rand_coord(cur_lo[0], cur_hi[0]), rand_coord(cur_lo[1], cur_hi[1]),
                       rand_coord(cur_lo[2], cur_hi[2]));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic signed [COORD_W-1:0] lo[MAX_AXES];
        logic signed [COORD_W-1:0] hi[MAX_AXES];

        foreach (cur_lo[i])
        begin
            cur_lo[i] = '0;
            cur_hi[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset box: a single point at the origin
        set_idling(0, 1, 0, 1);
        send_point('0, '0, '0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN);
        drain();

        // ordinary box, inside kept negative
        program_box(-10 * ONE, -5 * ONE, -2 * ONE, 10 * ONE, 5 * ONE, 2 * ONE, 1'b1);
        set_idling(3, 4, 30, 6);
        send_point('0, '0, '0);
        send_point(10 * ONE, '0, '0);
        send_point(10 * ONE, 5 * ONE, 2 * ONE);
        send_point(-10 * ONE, -5 * ONE, -2 * ONE);
        send_point(13 * ONE, '0, '0);
        send_point('0, -9 * ONE, '0);
        send_point('0, '0, 6 * ONE);
        send_point(13 * ONE, 9 * ONE, 6 * ONE);
        send_point(9 * ONE + ONE / 2, '0, '0);
        send_point('0, '0, -(ONE + 3 * ONE / 4));
        send_point(32'sd1, -32'sd1, '0);
        send_point(COORD_MAX, COORD_MIN, COORD_MAX);
        drain();

        // same box with the sign flipped
        program_box(-10 * ONE, -5 * ONE, -2 * ONE, 10 * ONE, 5 * ONE, 2 * ONE, 1'b0);
        send_point('0, '0, '0);
        send_point(13 * ONE, 9 * ONE, 6 * ONE);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        drain();

        // full-range box: every point is inside
        program_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_point('0, '0, '0);
        send_point(COORD_MAX, COORD_MIN, '0);
        drain();

        // inverted full-range box: largest distances the unit can produce, then random points
        program_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        set_idling(0, 1, 0, 1);
        run_random(100);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            for (int i = 0; i < MAX_AXES; i++)
                rand_span(lo[i], hi[i]);
            program_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom_range(1));
            case (ph % 4)
                0:       set_idling(0, 1, 0, 1);
                1:       set_idling(8, 6, 40, 20);
                2:       set_idling(2, 16, 10, 4);
                default: set_idling(0, 1, 60, 40);
            endcase
            run_random(PHASE_POINTS);
            drain();
        end

        repeat (PIPE_LATENCY + 8) @(posedge clk);

        $display("Sent %0d points over %0d box settings, %0d distances checked.",
                 points_sent, box_count + 1, sb.checked);
        $display("Mismatches: %0d", sb.fails);
        if (sb.fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
